@@ hw/rtl/srm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srm_pkg: shared types and constants of the schedule rule matcher
// Character codes, field layout, queue entry and configuration types.
// ----------------------------------------------------------------------------
package srm_pkg;

  localparam int PIN_SLOTS   = 8;
  localparam int SLOT_W      = 3;
  localparam int RULE_FIELDS = 8;
  localparam int FIELD_IDX_W = 3;
  localparam int ACC_W       = 15;
  localparam int FPOS_W      = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;

  localparam logic [ACC_W-1:0]  ACC_MAX  = ACC_W'(32767);
  localparam logic [FPOS_W-1:0] FPOS_MAX = FPOS_W'(15);

  // Character codes
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_C    = 8'h43;

  // Field positions within a rule line
  localparam logic [FIELD_IDX_W-1:0] FLD_MINUTE  = 3'd0;
  localparam logic [FIELD_IDX_W-1:0] FLD_HOUR    = 3'd1;
  localparam logic [FIELD_IDX_W-1:0] FLD_DAY     = 3'd2;
  localparam logic [FIELD_IDX_W-1:0] FLD_MONTH   = 3'd3;
  localparam logic [FIELD_IDX_W-1:0] FLD_WEEKDAY = 3'd4;
  localparam logic [FIELD_IDX_W-1:0] FLD_LENGTH  = 3'd5;
  localparam logic [FIELD_IDX_W-1:0] FLD_PIN     = 3'd6;
  localparam logic [FIELD_IDX_W-1:0] FLD_STATE   = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_SLOT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_NUMBER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOW_MINUTE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NOW_HOUR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NOW_DAY     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NOW_MONTH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NOW_WEEKDAY = 3'd6;

  // Weekday codes
  localparam logic [2:0] WD_SUNDAY   = 3'd1;
  localparam logic [2:0] WD_MONDAY   = 3'd2;
  localparam logic [2:0] WD_FRIDAY   = 3'd6;
  localparam logic [2:0] WD_SATURDAY = 3'd7;
  localparam logic [ACC_W-1:0] WD_WEEKEND = ACC_W'(8);
  localparam logic [ACC_W-1:0] WD_WORKDAY = ACC_W'(9);

  typedef struct packed {
    logic             wild;
    logic [ACC_W-1:0] val;
  } field_t;

  typedef struct packed {
    logic                         judge;
    logic                         finish;
    field_t [RULE_FIELDS-1:0]     fields;
  } entry_t;

  typedef struct packed {
    logic [2:0] pin_slot;
    logic [7:0] pin_number;
    logic [5:0] now_minute;
    logic [4:0] now_hour;
    logic [4:0] now_day;
    logic [3:0] now_month;
    logic [2:0] now_weekday;
  } cfg_t;

endpackage
`default_nettype wire

@@ hw/rtl/srm_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srm_front: byte parser
// Classifies text bytes, accumulates decimal fields and queues rule checks
// and end-of-text markers for the back end.
// ----------------------------------------------------------------------------
module srm_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_stall,
  input  wire logic [7:0]      in_text_byte,
  input  wire logic            in_final_byte,
  output srm_pkg::entry_t      push_data,
  output logic                 push
);
  import srm_pkg::*;

  logic [7:0]                kind_r, kind_nxt;
  logic [ACC_W-1:0]          acc_r, acc_nxt;
  logic                      pend_r, pend_nxt;
  logic [FPOS_W-1:0]         fpos_r, fpos_nxt;
  field_t [RULE_FIELDS-1:0]  fields_r, fields_nxt;
  field_t [RULE_FIELDS-1:0]  all_wild;
  logic                      accept;
  logic                      is_digit;
  logic                      judge;
  logic [ACC_W+3:0]          acc_ext;
  field_t                    store_val;
  logic                      do_store;

  assign accept = in_valid && !in_stall;
  assign is_digit = (in_text_byte >= CH_ZERO) && (in_text_byte <= CH_NINE);

  always_comb begin
    for (int k = 0; k < RULE_FIELDS; k++) begin
      all_wild[k] = '{wild: 1'b1, val: '0};
    end
  end

  always_comb begin
    kind_nxt   = kind_r;
    acc_nxt    = acc_r;
    pend_nxt   = pend_r;
    fpos_nxt   = fpos_r;
    fields_nxt = fields_r;
    judge      = 1'b0;
    do_store   = 1'b0;
    store_val  = '{wild: 1'b1, val: '0};
    acc_ext    = {{(ACC_W){1'b0}}, in_text_byte[3:0]};

    if (is_digit) begin
      if (pend_r) begin
        acc_ext = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} +
                  {{(ACC_W){1'b0}}, in_text_byte[3:0]};
      end
      acc_nxt  = (acc_ext > {4'b0000, ACC_MAX}) ? ACC_MAX : acc_ext[ACC_W-1:0];
      pend_nxt = 1'b1;
    end else if (kind_r == CH_NUL) begin
      kind_nxt = in_text_byte;
      acc_nxt  = '0;
      pend_nxt = 1'b0;
      fpos_nxt = '0;
      if (in_text_byte == CH_C) begin
        fields_nxt = all_wild;
      end
    end else if (in_text_byte == CH_STAR && kind_r == CH_C) begin
      do_store = 1'b1;
      acc_nxt  = '0;
      pend_nxt = 1'b0;
    end else if (pend_r) begin
      if (kind_r == CH_C) begin
        do_store  = 1'b1;
        store_val = '{wild: 1'b0, val: acc_r};
      end else if (fpos_r != FPOS_MAX) begin
        fpos_nxt = fpos_r + 1'b1;
      end
      acc_nxt  = '0;
      pend_nxt = 1'b0;
    end

    if (do_store) begin
      if (!fpos_r[FPOS_W-1]) begin
        fields_nxt[fpos_r[FIELD_IDX_W-1:0]] = store_val;
      end
      if (fpos_r != FPOS_MAX) begin
        fpos_nxt = fpos_r + 1'b1;
      end
    end

    if (in_text_byte == CH_LF || in_text_byte == CH_CR) begin
      judge    = (kind_nxt == CH_C);
      kind_nxt = CH_NUL;
    end
  end

  assign push = accept && (judge || in_final_byte);
  assign push_data = '{judge: judge, finish: in_final_byte, fields: fields_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= CH_NUL;
      acc_r    <= '0;
      pend_r   <= 1'b0;
      fpos_r   <= '0;
      fields_r <= all_wild;
    end else if (accept) begin
      if (in_final_byte) begin
        kind_r   <= CH_NUL;
        acc_r    <= '0;
        pend_r   <= 1'b0;
        fpos_r   <= '0;
        fields_r <= all_wild;
      end else begin
        kind_r   <= kind_nxt;
        acc_r    <= acc_nxt;
        pend_r   <= pend_nxt;
        fpos_r   <= fpos_nxt;
        fields_r <= fields_nxt;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/srm_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srm_queue: command queue
// Short first-in first-out buffer between the parser and the rule judge.
// ----------------------------------------------------------------------------
module srm_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire srm_pkg::entry_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output srm_pkg::entry_t      pop_data
);
  import srm_pkg::*;

  entry_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;
  logic               do_push;
  logic               do_pop;

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/srm_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srm_back: rule judge
// Checks completed rule lines against the current time, keeps the pass
// decision and the stored level of each slot, and holds the result register.
// ----------------------------------------------------------------------------
module srm_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire srm_pkg::cfg_t   cfg,
  input  wire logic            q_empty,
  input  wire srm_pkg::entry_t q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic                 out_pin_on,
  output logic                 out_level_changed
);
  import srm_pkg::*;

  typedef enum logic [1:0] {
    DEC_NONE = 2'd0,
    DEC_ON   = 2'd1,
    DEC_OFF  = 2'd2
  } decision_t;

  typedef enum logic [1:0] {
    LVL_UNKNOWN = 2'd0,
    LVL_OFF     = 2'd1,
    LVL_ON      = 2'd2
  } level_t;

  decision_t          decision_r;
  decision_t          dec_mid;
  level_t             slot_level_r [PIN_SLOTS];
  level_t             new_level;
  logic               out_valid_r;
  logic               out_pin_on_r;
  logic               out_changed_r;
  logic [SLOT_W-1:0]  slot;

  field_t mi, hr, dy, mo, wd, ln, pn, st;
  logic               applies;
  logic               day_ok, month_ok, wd_ok;
  logic               weekend, workday;
  logic               active;
  logic [10:0]        now_mod;
  logic [21:0]        start;
  logic [22:0]        stop;
  logic [ACC_W:0]     mi_stop;

  assign mi = q_data.fields[FLD_MINUTE];
  assign hr = q_data.fields[FLD_HOUR];
  assign dy = q_data.fields[FLD_DAY];
  assign mo = q_data.fields[FLD_MONTH];
  assign wd = q_data.fields[FLD_WEEKDAY];
  assign ln = q_data.fields[FLD_LENGTH];
  assign pn = q_data.fields[FLD_PIN];
  assign st = q_data.fields[FLD_STATE];

  assign slot = cfg.pin_slot[SLOT_W-1:0];

  always_comb begin
    weekend  = (cfg.now_weekday == WD_SUNDAY) || (cfg.now_weekday == WD_SATURDAY);
    workday  = (cfg.now_weekday >= WD_MONDAY) && (cfg.now_weekday <= WD_FRIDAY);
    day_ok   = dy.wild || (dy.val == ACC_W'(cfg.now_day));
    month_ok = mo.wild || (mo.val == ACC_W'(cfg.now_month));
    wd_ok    = wd.wild || (wd.val == WD_WEEKEND && weekend) ||
               (wd.val == WD_WORKDAY && workday) ||
               (wd.val == ACC_W'(cfg.now_weekday));
    applies  = !ln.wild && (ln.val != '0) && !pn.wild &&
               (pn.val == ACC_W'(cfg.pin_number)) && day_ok && month_ok && wd_ok;

    // Times in minutes: x * 60 is x * 64 - x * 4.
    now_mod = ({cfg.now_hour, 6'b0} - {4'b0, cfg.now_hour, 2'b0}) +
              {5'b0, cfg.now_minute};
    start   = ({1'b0, hr.val, 6'b0} - {5'b0, hr.val, 2'b0}) +
              {7'b0, mi.val};
    stop    = {1'b0, start} + {8'b0, ln.val};
    mi_stop = {1'b0, mi.val} + {1'b0, ln.val};

    active = 1'b0;
    if (!hr.wild) begin
      if (!mi.wild) begin
        active = (start <= {11'b0, now_mod}) && (stop > {12'b0, now_mod});
      end else begin
        active = (hr.val == ACC_W'(cfg.now_hour));
      end
    end else if (!mi.wild) begin
      active = (mi.val <= ACC_W'(cfg.now_minute)) &&
               (mi_stop > (ACC_W + 1)'(cfg.now_minute));
    end

    dec_mid = decision_r;
    if (q_data.judge && decision_r != DEC_OFF && applies && active) begin
      dec_mid = (!st.wild && st.val == '0) ? DEC_OFF : DEC_ON;
    end
    new_level = (dec_mid == DEC_ON) ? LVL_ON : LVL_OFF;
  end

  // An end-of-text entry waits until the result register can take it.
  assign q_pop = !q_empty && (!q_data.finish || !out_valid_r || !out_stall);

  assign out_valid         = out_valid_r;
  assign out_pin_on        = out_pin_on_r;
  assign out_level_changed = out_changed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decision_r  <= DEC_NONE;
      out_valid_r <= 1'b0;
      for (int k = 0; k < PIN_SLOTS; k++) begin
        slot_level_r[k] <= LVL_UNKNOWN;
      end
    end else begin
      if (q_pop) begin
        if (q_data.finish) begin
          decision_r         <= DEC_NONE;
          slot_level_r[slot] <= new_level;
        end else begin
          decision_r <= dec_mid;
        end
      end
      if (q_pop && q_data.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.finish) begin
      out_pin_on_r  <= (new_level == LVL_ON);
      out_changed_r <= (slot_level_r[slot] != new_level);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/schedule_rule_matcher_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// schedule_rule_matcher_core: schedule rule matcher top level
// Parses schedule text one byte per item and decides one pin's level.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_text_byte, in_final_byte)
//   takes one text byte per cycle while in_stall is low. Only an item with
//   in_final_byte high produces a result on the output channel (out_valid,
//   out_stall, out_pin_on, out_level_changed). A completed 'C' line and
//   the end of the text are handed to the rule judge through a two-entry
//   queue; the judge retires one entry per cycle unless an end-of-text
//   entry waits on a stalled result register. out_valid rises once the
//   final byte's entry has passed the queue into the result register.
//   Time and pin settings (cfg_we, cfg_index, cfg_data) must be written by
//   the user only while the block is idle; the block does not enforce it.
//   Reset clears the parser, the pending decision, all stored slot levels
//   (to unknown) and sets the settings to their defaults.
//   When the receiver stalls, the result register holds its item; the
//   queue absorbs up to two more entries before in_stall rises.
// ----------------------------------------------------------------------------
module schedule_rule_matcher_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [7:0]                        in_text_byte,
  input  wire logic                              in_final_byte,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_pin_on,
  output logic                                   out_level_changed,
  input  wire logic                              cfg_we,
  input  wire logic [srm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [srm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import srm_pkg::*;

  cfg_t   cfg_r;
  entry_t push_data;
  entry_t pop_data;
  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_empty;

  assign in_stall = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{pin_slot: 3'd0, pin_number: 8'd0, now_minute: 6'd0, now_hour: 5'd0,
                 now_day: 5'd1, now_month: 4'd1, now_weekday: 3'd1};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PIN_SLOT:    cfg_r.pin_slot    <= cfg_data[2:0];
        CFG_PIN_NUMBER:  cfg_r.pin_number  <= cfg_data[7:0];
        CFG_NOW_MINUTE:  cfg_r.now_minute  <= cfg_data[5:0];
        CFG_NOW_HOUR:    cfg_r.now_hour    <= cfg_data[4:0];
        CFG_NOW_DAY:     cfg_r.now_day     <= cfg_data[4:0];
        CFG_NOW_MONTH:   cfg_r.now_month   <= cfg_data[3:0];
        CFG_NOW_WEEKDAY: cfg_r.now_weekday <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  srm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (q_full),
    .in_text_byte  (in_text_byte),
    .in_final_byte (in_final_byte),
    .push_data     (push_data),
    .push          (push)
  );

  srm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .pop_data  (pop_data)
  );

  srm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_empty           (q_empty),
    .q_data            (pop_data),
    .q_pop             (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pin_on        (out_pin_on),
    .out_level_changed (out_level_changed)
  );

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for schedule_rule_matcher_core
// Streams schedule texts byte by byte under several time and pin settings and
// idling mixes, predicts each pin decision, and compares it with the result.
// ----------------------------------------------------------------------------
module tb_top;
  import srm_pkg::*;

  localparam int         QUIET_LIMIT = 2000;
  localparam int         HOLD_CYCLES = 400;
  localparam int         NO_VALUE    = -1;
  localparam logic [7:0] SEP_SPACE   = 8'h20;
  localparam logic [7:0] SEP_COMMA   = 8'h2C;
  localparam logic [7:0] KIND_D      = 8'h44;
  localparam logic [7:0] LETTER_A    = 8'h41;
  localparam logic [7:0] LETTER_Z    = 8'h5A;
  localparam field_t     WILD_FIELD  = '{wild: 1'b1, val: '0};

  typedef enum logic [1:0] {VERDICT_NONE, VERDICT_ON, VERDICT_OFF} verdict_t;
  typedef enum logic [1:0] {LEVEL_UNKNOWN, LEVEL_OFF, LEVEL_ON} level_t;
  typedef enum int {PICK_LOW, PICK_HIGH, PICK_RANDOM} cfg_pick_t;

  typedef struct packed {
    logic pin_on;
    logic level_changed;
  } pin_level_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_text_byte = '0;
  logic                  in_final_byte = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_pin_on;
  logic                  out_level_changed;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state: settings as the block holds them, parser and decision.
  cfg_t              now_cfg;
  logic [7:0]        txt_kind;
  logic [ACC_W-1:0]  num_acc;
  logic              num_pending;
  logic [FPOS_W-1:0] field_pos;
  field_t            rule_fld [RULE_FIELDS];
  verdict_t          verdict;
  level_t            slot_lvl [PIN_SLOTS];
  pin_level_t        pin_levels_due [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int bytes_sent = 0;
  int decisions_seen = 0;
  int on_seen = 0;
  int changed_seen = 0;
  int cfg_writes = 0;
  int fail_count = 0;

  schedule_rule_matcher_core dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_text_byte, .in_final_byte,
    .out_valid, .out_stall, .out_pin_on, .out_level_changed,
    .cfg_we, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic void clear_pass();
    int k;
    txt_kind = CH_NUL;
    num_acc = '0;
    num_pending = 1'b0;
    field_pos = '0;
    verdict = VERDICT_NONE;
    for (k = 0; k < RULE_FIELDS; k++) rule_fld[k] = WILD_FIELD;
  endfunction

  function automatic void reset_predictor();
    int k;
    now_cfg = '0;
    now_cfg.now_day = 5'd1;
    now_cfg.now_month = 4'd1;
    now_cfg.now_weekday = WD_SUNDAY;
    for (k = 0; k < PIN_SLOTS; k++) slot_lvl[k] = LEVEL_UNKNOWN;
    clear_pass();
  endfunction

  function automatic void store_field(input field_t f);
    if (field_pos < RULE_FIELDS) rule_fld[field_pos] = f;
    if (field_pos < FPOS_MAX) field_pos++;
  endfunction

  function automatic void judge_rule();
    field_t fm, fh, fd, fmo, fw, fl, fp, fs;
    int     mi, hr, ln, now_mod, start;
    logic   weekend, workday, active;
    fm = rule_fld[FLD_MINUTE];
    fh = rule_fld[FLD_HOUR];
    fd = rule_fld[FLD_DAY];
    fmo = rule_fld[FLD_MONTH];
    fw = rule_fld[FLD_WEEKDAY];
    fl = rule_fld[FLD_LENGTH];
    fp = rule_fld[FLD_PIN];
    fs = rule_fld[FLD_STATE];
    now_mod = int'(now_cfg.now_hour) * 60 + int'(now_cfg.now_minute);
    active = 1'b0;
    if (fl.wild || fl.val == '0 || fp.wild) return;
    if (fp.val != ACC_W'(now_cfg.pin_number)) return;
    if (!fd.wild && fd.val != ACC_W'(now_cfg.now_day)) return;
    if (!fmo.wild && fmo.val != ACC_W'(now_cfg.now_month)) return;
    if (!fw.wild) begin
      weekend = now_cfg.now_weekday == WD_SUNDAY || now_cfg.now_weekday == WD_SATURDAY;
      workday = now_cfg.now_weekday >= WD_MONDAY && now_cfg.now_weekday <= WD_FRIDAY;
      if (!((fw.val == WD_WEEKEND && weekend) || (fw.val == WD_WORKDAY && workday) ||
            fw.val == ACC_W'(now_cfg.now_weekday))) return;
    end
    mi = int'(fm.val);
    hr = int'(fh.val);
    ln = int'(fl.val);
    if (!fh.wild) begin
      if (!fm.wild) begin
        start = hr * 60 + mi;
        active = start <= now_mod && start + ln > now_mod;
      end else begin
        active = hr == int'(now_cfg.now_hour);
      end
    end else if (!fm.wild) begin
      active = mi <= int'(now_cfg.now_minute) && mi + ln > int'(now_cfg.now_minute);
    end
    if (active) verdict = (!fs.wild && fs.val == '0) ? VERDICT_OFF : VERDICT_ON;
  endfunction

  function automatic void parse_text_byte(input logic [7:0] c);
    int v;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = num_pending ? int'(num_acc) * 10 + int'(c - CH_ZERO) : int'(c - CH_ZERO);
      num_acc = (v > int'(ACC_MAX)) ? ACC_MAX : ACC_W'(v);
      num_pending = 1'b1;
    end else if (txt_kind == CH_NUL) begin
      txt_kind = c;
      num_acc = '0;
      num_pending = 1'b0;
      field_pos = '0;
      if (c == CH_C) begin
        for (v = 0; v < RULE_FIELDS; v++) rule_fld[v] = WILD_FIELD;
      end
    end else if (c == CH_STAR && txt_kind == CH_C) begin
      // A star also discards any digits that were still pending.
      store_field(WILD_FIELD);
      num_acc = '0;
      num_pending = 1'b0;
    end else if (num_pending) begin
      if (txt_kind == CH_C) store_field('{wild: 1'b0, val: num_acc});
      else if (field_pos < FPOS_MAX) field_pos++;
      num_acc = '0;
      num_pending = 1'b0;
    end
    if (c == CH_LF || c == CH_CR) begin
      if (txt_kind == CH_C) judge_rule();
      txt_kind = CH_NUL;
    end
  endfunction

  task automatic predict_pin_level(input logic [7:0] c, input logic last);
    pin_level_t want;
    level_t     lvl;
    int         slot;
    // Once a rule has switched the pin off, the rest of the text is skipped.
    if (verdict != VERDICT_OFF) parse_text_byte(c);
    if (last) begin
      want.pin_on = verdict == VERDICT_ON;
      lvl = want.pin_on ? LEVEL_ON : LEVEL_OFF;
      slot = int'(now_cfg.pin_slot) % PIN_SLOTS;
      want.level_changed = slot_lvl[slot] != lvl;
      slot_lvl[slot] = lvl;
      pin_levels_due.push_back(want);
      clear_pass();
    end
  endtask

  // ---------------------------------------------------------------- drivers

  task automatic send_item(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= c;
    in_final_byte <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_pin_level(c, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input logic [7:0] txt [$]);
    int i;
    for (i = 0; i < txt.size(); i++) send_item(txt[i], i == txt.size() - 1);
  endtask

  task automatic wait_drained(input int settle);
    while (pin_levels_due.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic put_setting(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_PIN_SLOT:    now_cfg.pin_slot = value[2:0];
      CFG_PIN_NUMBER:  now_cfg.pin_number = value;
      CFG_NOW_MINUTE:  now_cfg.now_minute = value[5:0];
      CFG_NOW_HOUR:    now_cfg.now_hour = value[4:0];
      CFG_NOW_DAY:     now_cfg.now_day = value[4:0];
      CFG_NOW_MONTH:   now_cfg.now_month = value[3:0];
      CFG_NOW_WEEKDAY: now_cfg.now_weekday = value[2:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic apply_settings(input cfg_pick_t pick);
    cfg_t c;
    case (pick)
      PICK_LOW:  c = '0;
      PICK_HIGH: c = '1;
      default: begin
        c.pin_slot = 3'($urandom_range(0, 7));
        c.pin_number = 8'($urandom_range(0, 255));
        c.now_minute = 6'(($urandom_range(99) < 90) ? $urandom_range(0, 59) :
                          $urandom_range(60, 63));
        c.now_hour = 5'(($urandom_range(99) < 90) ? $urandom_range(0, 23) :
                        $urandom_range(24, 31));
        c.now_day = 5'(($urandom_range(99) < 95) ? $urandom_range(1, 31) : 0);
        c.now_month = 4'(($urandom_range(99) < 90) ? $urandom_range(1, 12) :
                         $urandom_range(13, 15));
        c.now_weekday = 3'(($urandom_range(99) < 95) ? $urandom_range(1, 7) : 0);
      end
    endcase
    put_setting(CFG_PIN_SLOT, 8'(c.pin_slot));
    put_setting(CFG_PIN_NUMBER, c.pin_number);
    put_setting(CFG_NOW_MINUTE, 8'(c.now_minute));
    put_setting(CFG_NOW_HOUR, 8'(c.now_hour));
    put_setting(CFG_NOW_DAY, 8'(c.now_day));
    put_setting(CFG_NOW_MONTH, 8'(c.now_month));
    put_setting(CFG_NOW_WEEKDAY, 8'(c.now_weekday));
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------- text builder

  function automatic void push_chars(ref logic [7:0] txt [$], input string s);
    int i;
    for (i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endfunction

  function automatic void add_line_end(ref logic [7:0] txt [$]);
    int r;
    r = $urandom_range(99);
    if (r < 45) begin
      txt.push_back(CH_LF);
    end else if (r < 80) begin
      txt.push_back(CH_CR);
    end else begin
      txt.push_back(CH_CR);
      txt.push_back(CH_LF);
    end
  endfunction

  // Field values lean toward the current settings so that many rules fire.
  function automatic int rule_field_value(input int k);
    int r;
    r = $urandom_range(99);
    if (k >= RULE_FIELDS) return (r < 30) ? NO_VALUE : $urandom_range(0, 999);
    case (FIELD_IDX_W'(k))
      FLD_MINUTE: begin
        if (r < 25) return NO_VALUE;
        if (r < 60) return (now_cfg.now_minute > 20) ?
                           int'(now_cfg.now_minute) - int'($urandom_range(0, 20)) :
                           int'($urandom_range(0, now_cfg.now_minute));
        if (r < 70) return int'(now_cfg.now_minute) + 1;
        return $urandom_range(0, 59);
      end
      FLD_HOUR: begin
        if (r < 35) return NO_VALUE;
        if (r < 75) return int'(now_cfg.now_hour);
        if (r < 82) return (now_cfg.now_hour == 0) ? 23 : int'(now_cfg.now_hour) - 1;
        return $urandom_range(0, 23);
      end
      FLD_DAY: begin
        if (r < 60) return NO_VALUE;
        if (r < 85) return int'(now_cfg.now_day);
        return $urandom_range(0, 31);
      end
      FLD_MONTH: begin
        if (r < 60) return NO_VALUE;
        if (r < 85) return int'(now_cfg.now_month);
        return $urandom_range(0, 15);
      end
      FLD_WEEKDAY: begin
        if (r < 45) return NO_VALUE;
        if (r < 58) return int'(WD_WEEKEND);
        if (r < 71) return int'(WD_WORKDAY);
        if (r < 90) return int'(now_cfg.now_weekday);
        return $urandom_range(0, 9);
      end
      FLD_LENGTH: begin
        if (r < 5) return NO_VALUE;
        if (r < 10) return 0;
        if (r < 15) return 99999;
        if (r < 22) return $urandom_range(100, 1500);
        return $urandom_range(1, 60);
      end
      FLD_PIN: begin
        if (r < 8) return NO_VALUE;
        if (r < 80) return int'(now_cfg.pin_number);
        if (r < 95) return $urandom_range(0, 255);
        return $urandom_range(256, 40000);
      end
      default: begin
        if (r < 40) return 0;
        if (r < 80) return 1;
        if (r < 90) return NO_VALUE;
        return $urandom_range(2, 70000);
      end
    endcase
  endfunction

  function automatic void add_rule_line(ref logic [7:0] txt [$]);
    int n, k, v;
    // Digits ahead of the line letter are legal and must not disturb it.
    if ($urandom_range(99) < 5) push_chars(txt, $sformatf("%0d", $urandom_range(0, 99)));
    txt.push_back(CH_C);
    n = ($urandom_range(99) < 10) ? $urandom_range(6, 17) : RULE_FIELDS;
    for (k = 0; k < n; k++) begin
      txt.push_back(($urandom_range(99) < 80) ? SEP_SPACE : SEP_COMMA);
      v = rule_field_value(k);
      if (v == NO_VALUE) begin
        txt.push_back(CH_STAR);
      end else begin
        push_chars(txt, $sformatf("%0d", v));
        if ($urandom_range(99) < 3) txt.push_back(CH_STAR);
      end
    end
    add_line_end(txt);
  endfunction

  function automatic void add_other_line(ref logic [7:0] txt [$]);
    logic [7:0] kind;
    kind = 8'($urandom_range(LETTER_A, LETTER_Z));
    txt.push_back((kind == CH_C) ? KIND_D : kind);
    repeat ($urandom_range(1, 6)) begin
      txt.push_back(SEP_SPACE);
      push_chars(txt, $sformatf("%0d", $urandom_range(0, 9999)));
    end
    add_line_end(txt);
  endfunction

  function automatic void build_schedule_text(ref logic [7:0] txt [$]);
    int lines, k, r;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 12)) txt.push_back(8'($urandom_range(255)));
      return;
    end
    lines = ($urandom_range(99) < 60) ? 1 : $urandom_range(2, 3);
    for (k = 0; k < lines; k++) begin
      r = $urandom_range(99);
      if (r < 80) begin
        add_rule_line(txt);
      end else if (r < 90) begin
        add_other_line(txt);
      end else begin
        repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(255)));
        add_line_end(txt);
      end
    end
    if ($urandom_range(99) < 25) txt.push_back(8'($urandom_range(255)));
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_directed_texts();
    logic [7:0] txt [$];
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // Whole-hour rule without a state field: a wildcard state turns the pin on.
    push_chars(txt, "C* 0 * * * 1 0");
    txt.push_back(CH_LF);
    send_text(txt);
    txt.delete();
    // The oversized length saturates; state zero turns the pin off.
    push_chars(txt, "C* 0 * * * 99999 0 0");
    txt.push_back(CH_CR);
    send_text(txt);
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b1);
    in_valid <= 1'b0;
  endtask

  task automatic test_random_rules(input cfg_pick_t pick, input int idle_pct,
                                   input int stall_pct, input int n_bytes);
    logic [7:0] txt [$];
    int         first;
    wait_drained(4);
    apply_settings(pick);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    first = bytes_sent;
    while (bytes_sent - first < n_bytes) begin
      txt.delete();
      build_schedule_text(txt);
      send_text(txt);
    end
    in_valid <= 1'b0;
  endtask

  // The receiver holds off for a long stretch while texts keep coming, so the
  // result register and the judge queue fill up and the input stalls.
  task automatic test_long_hold();
    logic [7:0] txt [$];
    int         first;
    wait_drained(4);
    apply_settings(PICK_RANDOM);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = HOLD_CYCLES;
    first = bytes_sent;
    while (bytes_sent - first < 130) begin
      txt.delete();
      build_schedule_text(txt);
      send_text(txt);
    end
    in_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- processes

  initial begin
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= $urandom_range(99) < recv_stall_pct;
      end
    end
  end

  always @(posedge clk) begin
    pin_level_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pin_levels_due.size() == 0) begin
        $error("unexpected pin decision: pin_on %0b, level_changed %0b",
               out_pin_on, out_level_changed);
        fail_count++;
      end else begin
        want = pin_levels_due.pop_front();
        decisions_seen++;
        if (want.pin_on) on_seen++;
        if (want.level_changed) changed_seen++;
        if (out_pin_on !== want.pin_on) begin
          $error("pin_on: expected %0b, got %0b", want.pin_on, out_pin_on);
          fail_count++;
        end
        if (out_level_changed !== want.level_changed) begin
          $error("level_changed: expected %0b, got %0b", want.level_changed,
                 out_level_changed);
          fail_count++;
        end
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $error("no item moved for %0d cycles", QUIET_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    reset_predictor();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_texts();
    test_random_rules(PICK_HIGH, 0, 0, 145);
    test_random_rules(PICK_RANDOM, 0, 0, 145);
    test_random_rules(PICK_LOW, 87, 0, 145);
    test_random_rules(PICK_RANDOM, 87, 0, 145);
    test_random_rules(PICK_RANDOM, 0, 87, 145);
    test_random_rules(PICK_RANDOM, 0, 87, 145);
    test_random_rules(PICK_RANDOM, 38, 38, 145);
    test_random_rules(PICK_RANDOM, 38, 38, 145);
    test_long_hold();
    wait_drained(8);
    $display("Sent %0d text bytes and checked %0d pin decisions (%0d on, %0d level changes),",
             bytes_sent, decisions_seen, on_seen, changed_seen);
    $display("over %0d setting writes, four idling mixes and a long output hold-off.",
             cfg_writes);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
